// ===== design/lnvd_pkg.sv =====
// ----------------------------------------------------------------------------
// lnvd_pkg: shared types and constants
// Types and fixed constants used by the log-normalized vector difference
// block: the work item passed from the front end to the back end, and the
// arithmetic constants of the square root, log and divide pipelines.
// ----------------------------------------------------------------------------
package lnvd_pkg;

    // Output format: unsigned Q18.8, clamped at its maximum.
    localparam int OUT_W = 26;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Threshold reset value, 1.01 in Q16.16.
    localparam logic [31:0] THRESH_RESET = 32'd66191;

    // ln 2 in Q1.30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Pipeline step counts.
    localparam int LOG_FRAC   = 24;   // fraction bits of the log, one per step
    localparam int SQRT_STEPS = 17;   // result bits of the square root
    localparam int DIV_STEPS  = 26;   // quotient bits of the divider

    // Queue between front and back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One classified item on its way to the back end.
    typedef struct packed {
        logic        missing;   // observation absent
        logic        above;     // speed squared above the threshold
        logic [32:0] dsq;       // difference squared, Q.16
        logic [31:0] ssq;       // observed speed squared, Q16.16
    } t_work;

endpackage

// ===== design/wind_log_normalized_vector_diff.sv =====
// ----------------------------------------------------------------------------
// wind_log_normalized_vector_diff: wind log-normalized vector difference
// Top level: threshold register, front end, work queue and back end.
// ----------------------------------------------------------------------------
// The block takes one observation location per cycle while the input is not
// stalled and returns one result per location, in order, at a sustained rate
// of one per cycle while the output is not stalled. Latency from input
// transfer to result is set by the 24-step log pipeline (one squaring
// multiplier per step) followed by the 26-step restoring
// divider. A four-entry queue between the classifying front end and the
// arithmetic back end lets the input keep flowing for a few items while the
// output is stalled. The threshold register is written over its own port,
// which is always ready, and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module wind_log_normalized_vector_diff import lnvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_obs_east,
    input  logic signed [15:0] i_obs_north,
    input  logic signed [15:0] i_model_east,
    input  logic signed [15:0] i_model_north,
    input  logic               i_obs_present,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OUT_W-1:0]   o_lnvd_value,
    output logic               o_value_missing,
    output logic               o_saturated
);

    logic [31:0] r_threshold;
    logic        q_push, q_pop, q_full, q_empty;
    t_work       push_item, pop_item;

    // Threshold register; every write transfer updates it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Front end: squares and threshold classification.
    lnvd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_obs_east    (i_obs_east),
        .i_obs_north   (i_obs_north),
        .i_model_east  (i_model_east),
        .i_model_north (i_model_north),
        .i_obs_present (i_obs_present),
        .i_threshold   (r_threshold),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    // Work queue.
    lnvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_item  (pop_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: root, log, divide and output register.
    lnvd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_item        (pop_item),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_lnvd_value    (o_lnvd_value),
        .o_value_missing (o_value_missing),
        .o_saturated     (o_saturated)
    );

endmodule

// ===== design/lnvd_front.sv =====
// ----------------------------------------------------------------------------
// lnvd_front: input stage and classification
// Takes input transfers, forms the squared difference and the squared
// observed speed, compares the latter with the threshold and hands the
// classified item to the queue.
// ----------------------------------------------------------------------------
module lnvd_front import lnvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_obs_east,
    input  logic signed [15:0] i_obs_north,
    input  logic signed [15:0] i_model_east,
    input  logic signed [15:0] i_model_north,
    input  logic               i_obs_present,
    input  logic [31:0]        i_threshold,
    input  logic               i_q_full,
    output logic               o_push,
    output t_work              o_item
);

    logic        r1_valid, n1_valid;
    logic        r1_present;
    logic [31:0] r1_de2, n1_de2;
    logic [31:0] r1_dn2, n1_dn2;
    logic [30:0] r1_oe2, n1_oe2;
    logic [30:0] r1_on2, n1_on2;
    logic        r2_valid;
    t_work       r2_item, n2_item;
    logic        front_en;

    logic signed [16:0] de, dn;
    logic signed [33:0] de_sq, dn_sq;
    logic signed [31:0] oe_sq, on_sq;
    logic [32:0]        ssq_wide;

    // The front end moves unless its last stage holds an item the queue cannot take.
    assign front_en   = !(r2_valid && i_q_full);
    assign o_in_stall = !front_en;
    assign n1_valid   = i_in_valid;

    // Stage one: differences and the four squares.
    always_comb begin
        de     = $signed({i_obs_east[15], i_obs_east}) - $signed({i_model_east[15], i_model_east});
        dn     = $signed({i_obs_north[15], i_obs_north})
               - $signed({i_model_north[15], i_model_north});
        de_sq  = 34'(de) * 34'(de);
        dn_sq  = 34'(dn) * 34'(dn);
        oe_sq  = 32'(i_obs_east) * 32'(i_obs_east);
        on_sq  = 32'(i_obs_north) * 32'(i_obs_north);
        n1_de2 = de_sq[31:0];
        n1_dn2 = dn_sq[31:0];
        n1_oe2 = oe_sq[30:0];
        n1_on2 = on_sq[30:0];
    end

    // Stage two: sums and the threshold compare.
    always_comb begin
        ssq_wide        = {2'b00, r1_oe2} + {2'b00, r1_on2};
        n2_item.missing = !r1_present;
        n2_item.dsq     = {1'b0, r1_de2} + {1'b0, r1_dn2};
        n2_item.ssq     = ssq_wide[31:0];
        n2_item.above   = ssq_wide[31:0] > i_threshold;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (front_en) begin
            r1_valid <= n1_valid;
            r2_valid <= r1_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (front_en) begin
            r1_present <= i_obs_present;
            r1_de2     <= n1_de2;
            r1_dn2     <= n1_dn2;
            r1_oe2     <= n1_oe2;
            r1_on2     <= n1_on2;
            r2_item    <= n2_item;
        end
    end

    assign o_push = r2_valid && !i_q_full;
    assign o_item = r2_item;

endmodule

// ===== design/lnvd_queue.sv =====
// ----------------------------------------------------------------------------
// lnvd_queue: work queue
// A short first-in first-out queue that decouples the front end from the
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lnvd_queue import lnvd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_item,
    input  logic  i_pop,
    output t_work o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_work             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    // Occupancy follows the push and pop transfers.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // No push into a full queue and no pop from an empty one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// ===== design/lnvd_back.sv =====
// ----------------------------------------------------------------------------
// lnvd_back: arithmetic pipeline
// Square root of the difference, base-two log of the speed by repeated
// squaring, scaling to the natural log of the speed, a restoring divider
// and the output register with clamping.
// ----------------------------------------------------------------------------
module lnvd_back import lnvd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_work            i_q_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OUT_W-1:0] o_lnvd_value,
    output logic             o_value_missing,
    output logic             o_saturated
);

    localparam int LS = LOG_FRAC;   // last index of the log section
    localparam int DS = DIV_STEPS;  // last index of the divide section

    logic en;

    // Log and square root section.
    logic        r_lv     [LS+1];
    logic        r_lmiss  [LS+1];
    logic        r_labove [LS+1];
    logic [4:0]  r_ln     [LS+1];
    logic [30:0] r_lx     [LS+1];
    logic [23:0] r_lfrac  [LS+1];
    logic [33:0] r_srem   [LS+1];
    logic [33:0] r_sroot  [LS+1];

    // Scale stage.
    logic        r_gv, r_gmiss, r_gabove;
    logic [26:0] r_g, n_g;
    logic [16:0] r_gmag;

    // Divide section.
    logic        r_dv     [DS+1];
    logic        r_dmiss  [DS+1];
    logic        r_dabove [DS+1];
    logic        r_dsat   [DS+1];
    logic [16:0] r_dmag   [DS+1];
    logic [26:0] r_dg     [DS+1];
    logic [27:0] r_drem   [DS+1];
    logic [25:0] r_dnb    [DS+1];
    logic [25:0] r_dq     [DS+1];

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_value, n_out_value;
    logic             r_out_miss, n_out_miss;
    logic             r_out_sat, n_out_sat;

    // The whole back end advances when the output register is free or drains.
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_q_empty;

    // Entry stage: normalize the speed squared to Q1.30.
    logic [4:0]  n_ln0;
    logic [31:0] shl0;
    logic [30:0] n_lx0;
    always_comb begin
        n_ln0 = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_q_item.ssq[i]) begin
                n_ln0 = 5'(i);
            end
        end
        shl0 = i_q_item.ssq << (5'd30 - n_ln0);
        if (n_ln0 == 5'd31) begin
            n_lx0 = i_q_item.ssq[31:1];
        end else begin
            n_lx0 = shl0[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else if (en) begin
            r_lv[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lmiss[0]  <= i_q_item.missing;
            r_labove[0] <= i_q_item.above;
            r_ln[0]     <= n_ln0;
            r_lx[0]     <= n_lx0;
            r_lfrac[0]  <= '0;
            r_srem[0]   <= {1'b0, i_q_item.dsq};
            r_sroot[0]  <= '0;
        end
    end

    // One squaring step per stage; the square root runs alongside in the first stages.
    for (genvar k = 0; k < LS; k++) begin : g_log
        logic [61:0] sq;
        logic [31:0] y;
        logic [30:0] n_x;
        logic [23:0] n_frac;
        logic [33:0] n_rem, n_root;
        logic [34:0] trial;

        always_comb begin
            sq = 62'(r_lx[k]) * 62'(r_lx[k]);
            y  = sq[61:30];
            if (y[31]) begin
                n_x    = y[31:1];
                n_frac = {r_lfrac[k][22:0], 1'b1};
            end else begin
                n_x    = y[30:0];
                n_frac = {r_lfrac[k][22:0], 1'b0};
            end
            trial  = '0;
            n_rem  = r_srem[k];
            n_root = r_sroot[k];
            if (k < SQRT_STEPS) begin
                trial = {1'b0, r_sroot[k]} + (35'd1 << (2 * (SQRT_STEPS - 1 - k)));
                if ({1'b0, r_srem[k]} >= trial) begin
                    n_rem  = r_srem[k] - trial[33:0];
                    n_root = (r_sroot[k] >> 1) + (34'd1 << (2 * (SQRT_STEPS - 1 - k)));
                end else begin
                    n_root = r_sroot[k] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k+1] <= 1'b0;
            end else if (en) begin
                r_lv[k+1] <= r_lv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lmiss[k+1]  <= r_lmiss[k];
                r_labove[k+1] <= r_labove[k];
                r_ln[k+1]     <= r_ln[k];
                r_lx[k+1]     <= n_x;
                r_lfrac[k+1]  <= n_frac;
                r_srem[k+1]   <= n_rem;
                r_sroot[k+1]  <= n_root;
            end
        end
    end

    // Scale stage: natural log of the speed, zero when the log is not positive.
    logic        lpos;
    logic [3:0]  nexp;
    logic [27:0] lval;
    logic [57:0] gprod;
    always_comb begin
        nexp  = 4'(r_ln[LS] - 5'd16);
        lpos  = (r_ln[LS] >= 5'd16) && !((r_ln[LS] == 5'd16) && (r_lfrac[LS] == '0));
        lval  = {nexp, r_lfrac[LS]};
        gprod = 58'(lval) * 58'(LN2_Q30);
        n_g   = lpos ? gprod[57:31] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (en) begin
            r_gv <= r_lv[LS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gmiss  <= r_lmiss[LS];
            r_gabove <= r_labove[LS];
            r_g      <= n_g;
            r_gmag   <= r_sroot[LS][16:0];
        end
    end

    // Divider setup: a quotient of 2^26 or more means the magnitude is at least 4 g.
    logic n_dsat0;
    always_comb begin
        n_dsat0 = (r_g == '0) || ({12'd0, r_gmag} >= {r_g, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmiss[0]  <= r_gmiss;
            r_dabove[0] <= r_gabove;
            r_dsat[0]   <= n_dsat0;
            r_dmag[0]   <= r_gmag;
            r_dg[0]     <= r_g;
            r_drem[0]   <= {13'd0, r_gmag[16:2]};
            r_dnb[0]    <= {r_gmag[1:0], 24'd0};
            r_dq[0]     <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [27:0] shifted, n_rem;
        logic [25:0] n_q;

        always_comb begin
            shifted = {r_drem[k][26:0], r_dnb[k][25]};
            if (shifted >= {1'b0, r_dg[k]}) begin
                n_rem = shifted - {1'b0, r_dg[k]};
                n_q   = {r_dq[k][24:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_dq[k][24:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dmiss[k+1]  <= r_dmiss[k];
                r_dabove[k+1] <= r_dabove[k];
                r_dsat[k+1]   <= r_dsat[k];
                r_dmag[k+1]   <= r_dmag[k];
                r_dg[k+1]     <= r_dg[k];
                r_drem[k+1]   <= n_rem;
                r_dnb[k+1]    <= {r_dnb[k][24:0], 1'b0};
                r_dq[k+1]     <= n_q;
            end
        end
    end

    // Result selection.
    always_comb begin
        n_out_miss  = 1'b0;
        n_out_sat   = 1'b0;
        n_out_value = r_dq[DS];
        if (r_dmiss[DS]) begin
            n_out_miss  = 1'b1;
            n_out_value = '0;
        end else if (!r_dabove[DS]) begin
            n_out_value = {{(OUT_W-17){1'b0}}, r_dmag[DS]};
        end else if (r_dsat[DS]) begin
            n_out_sat   = 1'b1;
            n_out_value = OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value <= n_out_value;
            r_out_miss  <= n_out_miss;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lnvd_value    = r_out_value;
    assign o_value_missing = r_out_miss;
    assign o_saturated     = r_out_sat;

    // A clamped result always carries the maximum value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sat |-> r_out_value == OUT_MAX)
        else $error("saturated result not at maximum");
    // A missing observation gives zero and never saturates.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_miss |-> r_out_value == '0 && !r_out_sat)
        else $error("missing result not cleared");
    // While the output is held, nothing is taken from the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !o_pop)
        else $error("queue popped while output stalled");

endmodule
